// ===== hw/rtl/bm3_pkg.sv =====
// bm3_pkg: shared types, register indexes and helpers for the 3x3 binary morphology unit.
// No dependencies; imported by bm3_cell, bm3_pass, the top unit and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package bm3_pkg;

    localparam int PIX_W  = 8;
    localparam int POS_W  = 15;
    localparam int ROW_W  = 13;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 12;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_WIDTH  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IW-1:0] REG_FG     = 3'd3;
    localparam logic [CFG_IW-1:0] REG_BG     = 3'd4;

    // mode codes
    localparam logic [1:0] MODE_DILATE = 2'd0;
    localparam logic [1:0] MODE_ERODE  = 2'd1;
    localparam logic [1:0] MODE_OPEN   = 2'd2;
    localparam logic [1:0] MODE_CLOSE  = 2'd3;

    localparam logic [11:0] MIN_SIZE = 12'd3;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [2:0][PIX_W-1:0] pix_col_t;   // [0] top row .. [2] newest row
    typedef logic signed [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [2:0] row_ok;
        logic [2:0] col_ok;
    } mask_t;

    typedef struct packed {
        pix_t check;
        pix_t fill;
    } rule_t;

    // interior flags (1 .. lim-2) for the three window offsets around one center coordinate
    function automatic logic [2:0] inner_flags(input pos_t center, input pos_t lim);
        logic [2:0] f;
        pos_t q;
        for (int k = 0; k < 3; k++)
        begin
            q = center - pos_t'(1) + pos_t'(k);
            f[k] = (q >= pos_t'(1)) && (q <= lim - pos_t'(2));
        end
        return f;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bm3_ram.sv =====
// bm3_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bm3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bm3_cell.sv =====
// bm3_cell: one window column of three pixels, handed to the next cell on each shift.
// Depends on bm3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bm3_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift,
    input  wire bm3_pkg::pix_col_t col_in,
    output bm3_pkg::pix_col_t      col_q
);
    import bm3_pkg::*;

    pix_col_t col_reg;
    pix_col_t col_next;

    assign col_next = shift ? col_in : col_reg;
    assign col_q    = col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bm3_pass.sv =====
// bm3_pass: one morphology pass: two-row line store, chain of three window cells, decision.
// Depends on bm3_pkg, bm3_ram and bm3_cell.
`timescale 1ns / 1ps
`default_nettype none
module bm3_pass #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  wire logic                         push,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  wire bm3_pkg::pix_t                pix,
    input  wire bm3_pkg::mask_t               mask,
    input  wire bm3_pkg::rule_t               rule,
    output bm3_pkg::pix_t                     res
);
    import bm3_pkg::*;

    logic [2*PIX_W-1:0] line_q;     // {older, prev}
    pix_col_t           new_col;
    pix_col_t           win [3];    // [0] oldest column .. [2] newest
    logic               hit;

    bm3_ram #(
        .WIDTH(2 * PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_lines (
        .clk  (clk),
        .we   (push),
        .waddr(wr_addr),
        .wdata({line_q[PIX_W-1:0], pix}),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(line_q)
    );

    assign new_col[0] = line_q[2*PIX_W-1:PIX_W];
    assign new_col[1] = line_q[PIX_W-1:0];
    assign new_col[2] = pix;

    genvar k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_cell
            bm3_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (push),
                .col_in((k == 2) ? new_col : win[(k == 2) ? 2 : k + 1]),
                .col_q (win[k])
            );
        end
    endgenerate

    always_comb
    begin
        hit = 1'b0;
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                if (mask.row_ok[dr] && mask.col_ok[dc] && (win[dc][dr] != rule.check))
                begin
                    hit = 1'b1;
                end
            end
        end
        res = hit ? rule.fill : win[1][1];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/binary_morphology_3x3_unit.sv =====
// binary_morphology_3x3_unit: streaming 3x3 binary dilation, erosion, open and close.
// Depends on bm3_pkg and bm3_pass (which uses bm3_ram and bm3_cell).
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready   | tdata: pixel; tuser: req_type
//  m_axis    | out | m_axis_tvalid/tready   | tdata: out_pixel; tlast: last
//  cfg       | in  | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// One item per clock sustained. An item passes the pipeline stages S0..S2
// and then sits in the output register; each pass has one line-store RAM whose
// read is issued one stage ahead of its write-back. A result appears W+1 items
// (one pass) or 2*(W+1) items (two passes) after its pixel. Reset clears counters,
// valid bits and window cells; line stores are not cleared. When the output
// register is full and not taken, the whole pipeline holds and s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module binary_morphology_3x3_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,   // [7:0] pixel
    input  wire logic [0:0]                  s_axis_tuser,   // [0] req_type
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [7:0]                       m_axis_tdata,   // [7:0] out_pixel
    output logic                             m_axis_tlast,
    input  wire logic                        cfg_we,
    input  wire logic [bm3_pkg::CFG_IW-1:0]  cfg_index,
    input  wire logic [bm3_pkg::CFG_DW-1:0]  cfg_wdata
);
    import bm3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // configuration
    logic [1:0]  mode_reg;
    logic [10:0] fw_reg;
    logic [11:0] fh_reg;
    pix_t        fg_reg;
    pix_t        bg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DILATE;
            fw_reg   <= 11'd1024;
            fh_reg   <= 12'd768;
            fg_reg   <= 8'd0;
            bg_reg   <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg <= cfg_wdata[1:0];
                REG_WIDTH:  fw_reg   <= cfg_wdata[10:0];
                REG_HEIGHT: fh_reg   <= cfg_wdata[11:0];
                REG_FG:     fg_reg   <= cfg_wdata[7:0];
                REG_BG:     bg_reg   <= cfg_wdata[7:0];
                default:    ;
            endcase
        end
    end

    // clamp frame size
    pos_t w_c;
    pos_t h_c;
    always_comb
    begin
        priority if (fw_reg < 11'(MIN_SIZE))
            w_c = pos_t'(MIN_SIZE);
        else if (POS_W'(fw_reg) > POS_W'(MAX_WIDTH))
            w_c = pos_t'(MAX_WIDTH);
        else
            w_c = pos_t'(fw_reg);
        h_c = (fh_reg < MIN_SIZE) ? pos_t'(MIN_SIZE) : pos_t'(fh_reg);
    end

    logic erode_first;
    logic two_pass;
    rule_t rule1;
    rule_t rule2;
    assign erode_first = (mode_reg == MODE_ERODE) || (mode_reg == MODE_OPEN);
    assign two_pass    = (mode_reg == MODE_OPEN) || (mode_reg == MODE_CLOSE);
    assign rule1.check = erode_first ? fg_reg : bg_reg;
    assign rule1.fill  = erode_first ? bg_reg : fg_reg;
    assign rule2.check = rule1.fill;
    assign rule2.fill  = rule1.check;

    // stall control: everything advances when the output register can take a result
    logic out_valid_reg;
    logic adv;
    logic accept;
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    // input position and per-item geometry, worked out at acceptance
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [CW-1:0]    in_col_reg, in_col_next;

    logic  in_frame, flush, drop, enter;
    pos_t  r0, c0, p1r, p1c, p2r, p2c, pfr, pfc;
    logic  emit, last;
    pix_t  v;
    mask_t m1, m2;

    always_comb
    begin
        r0       = pos_t'(in_row_reg);
        c0       = pos_t'(in_col_reg);
        flush    = s_axis_tuser[0];
        in_frame = r0 < h_c;
        drop     = flush && in_frame;
        enter    = accept && !drop;
        v        = (!flush && in_frame) ? s_axis_tdata : '0;

        if (c0 >= pos_t'(1))
        begin
            p1r = r0 - pos_t'(1);
            p1c = c0 - pos_t'(1);
        end
        else
        begin
            p1r = r0 - pos_t'(2);
            p1c = w_c - pos_t'(1);
        end
        if (p1c >= pos_t'(1))
        begin
            p2r = p1r - pos_t'(1);
            p2c = p1c - pos_t'(1);
        end
        else
        begin
            p2r = p1r - pos_t'(2);
            p2c = w_c - pos_t'(1);
        end
        pfr = two_pass ? p2r : p1r;
        pfc = two_pass ? p2c : p1c;

        emit = pfr >= pos_t'(0);
        last = emit && ((pfr > h_c - pos_t'(1)) ||
                        ((pfr == h_c - pos_t'(1)) && (pfc >= w_c - pos_t'(1))));

        m1.row_ok = inner_flags(p1r, h_c);
        m1.col_ok = inner_flags(p1c, w_c);
        m2.row_ok = inner_flags(p2r, h_c);
        m2.col_ok = inner_flags(p2c, w_c);

        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        if (enter)
        begin
            if (c0 + pos_t'(1) >= w_c)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (last)
            begin
                in_row_next = '0;
                in_col_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
        end
        else
        begin
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
        end
    end

    // pipeline: S0 pass-1 write, S1 pass-1 decide / pass-2 write, S2 pass-2 decide
    logic          s0_valid_reg, s1_valid_reg, s2_valid_reg;
    pix_t          s0_v_reg;
    logic [CW-1:0] s0_a1_reg, s0_a2_reg, s1_a2_reg;
    mask_t         s0_m1_reg, s0_m2_reg, s1_m1_reg, s1_m2_reg, s2_m2_reg;
    logic          s0_two_reg, s1_two_reg, s2_two_reg;
    logic          s0_emit_reg, s1_emit_reg, s2_emit_reg;
    logic          s0_last_reg, s1_last_reg, s2_last_reg;
    pix_t          s2_res1_reg;
    pix_t          res1, res2;
    pix_t          out_pix_reg;
    logic          out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg  <= enter;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_emit_reg;
        end
    end

    // payload: advance with the pipeline, no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_v_reg     <= v;
            s0_a1_reg    <= in_col_reg;
            s0_a2_reg    <= p1c[CW-1:0];
            s0_m1_reg    <= m1;
            s0_m2_reg    <= m2;
            s0_two_reg   <= two_pass;
            s0_emit_reg  <= emit;
            s0_last_reg  <= last;

            s1_a2_reg    <= s0_a2_reg;
            s1_m1_reg    <= s0_m1_reg;
            s1_m2_reg    <= s0_m2_reg;
            s1_two_reg   <= s0_two_reg;
            s1_emit_reg  <= s0_emit_reg;
            s1_last_reg  <= s0_last_reg;

            s2_res1_reg  <= res1;
            s2_m2_reg    <= s1_m2_reg;
            s2_two_reg   <= s1_two_reg;
            s2_emit_reg  <= s1_emit_reg;
            s2_last_reg  <= s1_last_reg;

            out_pix_reg  <= s2_two_reg ? res2 : s2_res1_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    // first pass: read the line store as the item enters, write it back from S0
    bm3_pass #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_pass1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (enter),
        .rd_addr(in_col_reg),
        .push   (adv && s0_valid_reg),
        .wr_addr(s0_a1_reg),
        .pix    (s0_v_reg),
        .mask   (s1_m1_reg),
        .rule   (rule1),
        .res    (res1)
    );

    // second pass: fed with the first-pass result in S1; idle in single-pass modes
    bm3_pass #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_pass2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (adv && s0_valid_reg && s0_two_reg),
        .rd_addr(s0_a2_reg),
        .push   (adv && s1_valid_reg && s1_two_reg),
        .wr_addr(s1_a2_reg),
        .pix    (res1),
        .mask   (s2_m2_reg),
        .rule   (rule2),
        .res    (res2)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bm3_checker.sv =====
// bm3_checker: port-level assertions for binary_morphology_3x3_unit, and the bind.
// Depends on binary_morphology_3x3_unit.
`timescale 1ns / 1ps
`default_nettype none
module bm3_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);

    // hold a stalled result
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // input side is open whenever the output register is empty or draining
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |-> s_axis_tready)
        else $error("input blocked while output drains");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

endmodule

bind binary_morphology_3x3_unit bm3_checker u_bm3_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);
`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for binary_morphology_3x3_unit.
// Depends on bm3_pkg and the RTL of the unit; checks every item against a built-in predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import bm3_pkg::*;

    localparam int LINE_MAX   = 1024;
    localparam int TIME_LIMIT = 800000;

    typedef struct {
        logic [7:0] pix;
        logic       last;
    } morph_res_t;

    // one row of the directed table: register mode, item fields, optional typed result
    typedef struct {
        logic [1:0] mode;
        logic       req;
        logic [7:0] pix;
        bit         known;
        logic [7:0] epix;
        logic       elast;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;

    binary_morphology_3x3_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state: its own copy of registers, line stores and windows
    logic [1:0]  p_mode;
    logic [10:0] p_width;
    logic [11:0] p_height;
    logic [7:0]  p_fg, p_bg;
    logic [7:0]  line_mem [2][2*LINE_MAX];
    logic [7:0]  win_mem [2][9];
    int          in_row, in_col;
    bit          frame_closed;     // set when the predictor emits last=1

    morph_res_t  morph_q[$];
    int          err_cnt = 0;
    int          cycle_cnt = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // One 3x3 pass: shift the pixel into the line store and window, rule on the delayed pixel
    function automatic logic [7:0] morph_pass(int p, int r, int c, logic [7:0] v,
                                              int w, int h, logic [7:0] chk,
                                              logic [7:0] fill, output int orow,
                                              output int ocol);
        logic [7:0] older, prev, res;
        int pr, pc;
        older = '0;
        prev = '0;
        if (c >= 0 && c < LINE_MAX)
        begin
            older = line_mem[p][c];
            prev = line_mem[p][LINE_MAX + c];
            line_mem[p][c] = prev;
            line_mem[p][LINE_MAX + c] = v;
        end
        for (int dr = 0; dr < 3; dr++)
        begin
            win_mem[p][dr*3] = win_mem[p][dr*3 + 1];
            win_mem[p][dr*3 + 1] = win_mem[p][dr*3 + 2];
        end
        win_mem[p][2] = older;
        win_mem[p][5] = prev;
        win_mem[p][8] = v;
        if (c >= 1)
        begin
            orow = r - 1;
            ocol = c - 1;
        end
        else
        begin
            orow = r - 2;
            ocol = w - 1;
        end
        res = win_mem[p][4];
        for (int dr = 0; dr < 3; dr++)
            for (int dc = 0; dc < 3; dc++)
            begin
                pr = orow - 1 + dr;
                pc = ocol - 1 + dc;
                if (pr >= 1 && pr <= h - 2 && pc >= 1 && pc <= w - 2 &&
                    win_mem[p][dr*3 + dc] != chk)
                    res = fill;
            end
        return res;
    endfunction

    // Advance the predictor by one accepted item; report whether a result follows
    function automatic bit morph_predict(logic req, logic [7:0] pix, output morph_res_t res);
        int w, h, r1, c1, r2, c2;
        bit ero_first, two_pass, in_frame, last;
        logic [7:0] v, val;
        w = int'(p_width);
        h = int'(p_height);
        if (w < 3) w = 3;
        if (w > LINE_MAX) w = LINE_MAX;
        if (h < 3) h = 3;
        res.pix = '0;
        res.last = 1'b0;
        in_frame = in_row < h;
        if (req && in_frame)
            return 1'b0;
        v = (!req && in_frame) ? pix : 8'd0;
        ero_first = (p_mode == MODE_ERODE || p_mode == MODE_OPEN);
        two_pass = (p_mode == MODE_OPEN || p_mode == MODE_CLOSE);
        val = morph_pass(0, in_row, in_col, v, w, h, ero_first ? p_fg : p_bg,
                         ero_first ? p_bg : p_fg, r1, c1);
        r2 = r1;
        c2 = c1;
        if (two_pass)
            val = morph_pass(1, r1, c1, val, w, h, ero_first ? p_bg : p_fg,
                             ero_first ? p_fg : p_bg, r2, c2);
        if (in_col + 1 >= w)
        begin
            in_col = 0;
            in_row++;
        end
        else
            in_col++;
        if (r2 < 0)
            return 1'b0;
        last = (r2 > h - 1) || (r2 == h - 1 && c2 >= w - 1);
        if (last)
        begin
            in_row = 0;
            in_col = 0;
            frame_closed = 1'b1;
        end
        res.pix = val;
        res.last = last;
        return 1'b1;
    endfunction

    // Write one register; the predictor takes the same masked value
    task automatic write_reg(logic [CFG_IW-1:0] idx, int value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = CFG_DW'(value);
        case (idx)
            REG_MODE:   p_mode = value[1:0];
            REG_WIDTH:  p_width = value[10:0];
            REG_HEIGHT: p_height = value[11:0];
            REG_FG:     p_fg = value[7:0];
            REG_BG:     p_bg = value[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Drop valid, drain every expected result, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (morph_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Present one item and hold it until accepted; optionally force the typed result
    task automatic send_item(logic req, logic [7:0] pix, bit known, morph_res_t typed);
        morph_res_t res;
        bit has;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = req;
        s_axis_tdata = pix;
        do
            @(posedge clk);
        while (!s_axis_tready);
        has = morph_predict(req, pix, res);
        if (known)
            morph_q.push_back(typed);
        else if (has)
            morph_q.push_back(res);
    endtask

    task automatic send(logic req, logic [7:0] pix);
        morph_res_t none;
        none.pix = '0;
        none.last = 1'b0;
        send_item(req, pix, 1'b0, none);
    endtask

    // Pick a pixel: mostly the two coded values, sometimes any gray value
    function automatic logic [7:0] pick_pixel();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) return p_fg;
        if (sel < 8) return p_bg;
        return 8'($urandom);
    endfunction

    // One whole frame with random content, stray early flushes, then flush until last
    task automatic run_frame(int w, int h, int noise_pct);
        frame_closed = 1'b0;
        for (int k = 0; k < w * h; k++)
        begin
            if ($urandom_range(99) < noise_pct)
                send(1'b1, 8'($urandom));   // early flush: ignored
            send(1'b0, pick_pixel());
        end
        // extra pixels after the frame count as flush ticks
        while (!frame_closed)
            send($urandom_range(3) != 0, 8'($urandom));
    endtask

    // Receiver: stall at random, compare each taken item with the oldest expectation
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        morph_res_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (morph_q.size() == 0)
            begin
                $error("unexpected result out_pixel=%0d last=%0b", m_axis_tdata, m_axis_tlast);
                err_cnt++;
            end
            else
            begin
                e = morph_q.pop_front();
                if (m_axis_tdata !== e.pix)
                begin
                    $error("out_pixel: expected %0d, actual %0d", e.pix, m_axis_tdata);
                    err_cnt++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $error("last: expected %0b, actual %0b", e.last, m_axis_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // Hard stop for a hung handshake
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > TIME_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Directed table. Dilation frame 3x3: only the center is interior, so one non-background
    // center turns every output pixel to foreground (0). Erosion frame: a center that is not
    // foreground turns every output to background (255); extra pixels act as flush ticks.
    stim_row_t dir_tab[] = '{
        '{MODE_DILATE, 1'b1, 8'd9,   1'b0, 8'd0,   1'b0},   // early flush: no result
        '{MODE_DILATE, 1'b0, 8'd255, 1'b0, 8'd0,   1'b0},
        '{MODE_DILATE, 1'b0, 8'd255, 1'b0, 8'd0,   1'b0},
        '{MODE_DILATE, 1'b0, 8'd255, 1'b0, 8'd0,   1'b0},
        '{MODE_DILATE, 1'b0, 8'd255, 1'b0, 8'd0,   1'b0},
        '{MODE_DILATE, 1'b0, 8'd7,   1'b1, 8'd0,   1'b0},
        '{MODE_DILATE, 1'b0, 8'd255, 1'b1, 8'd0,   1'b0},
        '{MODE_DILATE, 1'b0, 8'd255, 1'b1, 8'd0,   1'b0},
        '{MODE_DILATE, 1'b0, 8'd255, 1'b1, 8'd0,   1'b0},
        '{MODE_DILATE, 1'b0, 8'd255, 1'b1, 8'd0,   1'b0},
        '{MODE_DILATE, 1'b1, 8'd0,   1'b1, 8'd0,   1'b0},
        '{MODE_DILATE, 1'b1, 8'd0,   1'b1, 8'd0,   1'b0},
        '{MODE_DILATE, 1'b1, 8'd0,   1'b1, 8'd0,   1'b0},
        '{MODE_DILATE, 1'b1, 8'd0,   1'b1, 8'd0,   1'b1},
        '{MODE_ERODE,  1'b0, 8'd0,   1'b0, 8'd0,   1'b0},
        '{MODE_ERODE,  1'b0, 8'd0,   1'b0, 8'd0,   1'b0},
        '{MODE_ERODE,  1'b0, 8'd0,   1'b0, 8'd0,   1'b0},
        '{MODE_ERODE,  1'b0, 8'd0,   1'b0, 8'd0,   1'b0},
        '{MODE_ERODE,  1'b0, 8'd255, 1'b1, 8'd255, 1'b0},
        '{MODE_ERODE,  1'b0, 8'd0,   1'b1, 8'd255, 1'b0},
        '{MODE_ERODE,  1'b0, 8'd0,   1'b1, 8'd255, 1'b0},
        '{MODE_ERODE,  1'b0, 8'd0,   1'b1, 8'd255, 1'b0},
        '{MODE_ERODE,  1'b0, 8'd0,   1'b1, 8'd255, 1'b0},
        '{MODE_ERODE,  1'b0, 8'd128, 1'b1, 8'd255, 1'b0},
        '{MODE_ERODE,  1'b0, 8'd1,   1'b1, 8'd255, 1'b0},
        '{MODE_ERODE,  1'b0, 8'd254, 1'b1, 8'd255, 1'b0},
        '{MODE_ERODE,  1'b1, 8'd0,   1'b1, 8'd255, 1'b1}
    };

    initial
    begin
        morph_res_t typed;
        int items, frames, w, h;
        // predictor reset values
        p_mode = MODE_DILATE;
        p_width = 11'd1024;
        p_height = 12'd768;
        p_fg = 8'd0;
        p_bg = 8'd255;
        in_row = 0;
        in_col = 0;
        frame_closed = 1'b0;
        for (int p = 0; p < 2; p++)
        begin
            for (int k = 0; k < 9; k++)
                win_mem[p][k] = '0;
            for (int k = 0; k < 2*LINE_MAX; k++)
                line_mem[p][k] = '0;
        end

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // directed part, no idling
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 3);
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].mode != p_mode)
            begin
                wait_idle();
                write_reg(REG_MODE, dir_tab[i].mode);
            end
            typed.pix = dir_tab[i].epix;
            typed.last = dir_tab[i].elast;
            send_item(dir_tab[i].req, dir_tab[i].pix, dir_tab[i].known, typed);
        end
        wait_idle();

        // size extremes: sizes below the minimum clamp to 3, extreme and equal codes
        write_reg(REG_MODE, MODE_CLOSE);
        write_reg(REG_WIDTH, 0);             // clamps to 3 columns
        write_reg(REG_HEIGHT, 0);            // clamps to 3 rows
        write_reg(REG_FG, 255);
        write_reg(REG_BG, 0);
        run_frame(3, 3, 0);
        wait_idle();
        write_reg(REG_MODE, MODE_OPEN);
        write_reg(REG_WIDTH, 2);             // clamps to 3 columns
        write_reg(REG_HEIGHT, 1);            // clamps to 3 rows
        write_reg(REG_FG, 0);
        write_reg(REG_BG, 0);                // equal codes: rules apply unchanged
        run_frame(3, 3, 0);
        wait_idle();

        // random frames, idling phases rotate from one frame pair to the next
        items = 0;
        frames = 0;
        while (items < 420)
        begin
            case (frames % 5)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                3: begin send_idle_pct = 31; recv_stall_pct = 31; end
                default: begin send_idle_pct = $urandom_range(50); recv_stall_pct = 0; end
            endcase
            w = $urandom_range(3, 9);
            h = $urandom_range(3, 7);
            write_reg(REG_MODE, $urandom_range(3));
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, h);
            write_reg(REG_FG, $urandom_range(255));
            if ($urandom_range(9) == 0)
                write_reg(REG_BG, p_fg);
            else
                write_reg(REG_BG, $urandom_range(255));
            // two back-to-back frames under one setting: the second starts right after last
            run_frame(w, h, 8);
            run_frame(w, h, 8);
            items += 2 * w * h;
            frames++;
            wait_idle();
        end

        // end of stimulus: drain and settle
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_idle();
        repeat (20) @(negedge clk);
        if (err_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/bm3_pkg.sv
hw/rtl/bm3_ram.sv
hw/rtl/bm3_cell.sv
hw/rtl/bm3_pass.sv
hw/rtl/binary_morphology_3x3_unit.sv
hw/rtl/bm3_checker.sv
verif/tb_top.sv
